[hdl/assert_macros.svh]
// Assertion macros for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

[hdl/lcmgcd_pkg.sv]
`default_nettype none
package lcmgcd_pkg;
    localparam int MaxValues = 8;
    localparam int MaxSteps = 32;
    localparam int IdxW = $clog2(MaxValues);
    localparam int CntW = $clog2(MaxValues + 1);
    localparam int StepW = $clog2(MaxSteps + 1);

    typedef enum logic [1:0] {
        KIND_STEP = 2'd0,
        KIND_SIMPLE = 2'd1,
        KIND_SUMMARY = 2'd2
    } kind_t;

    typedef struct packed {
        logic [15:0] value;
        logic        last_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] item_value;
        logic [31:0] lcm_value;
        logic [15:0] gcd_value;
        logic        overflow;
        logic        last_result;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SCAN,       // check working value idx: >1, then start divider
        ST_DIV_WAIT,   // divider running on working value
        ST_STEP_END,   // end of a pass over values
        ST_MUL,        // lcm/gcd update
        ST_OUT_DIV,    // divide original by gcd
        ST_OUT_WAIT,
        ST_OUT_EMIT,
        ST_SUMMARY
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_start;     // begin pass: idx=0, hit/any cleared, all set
        logic div_start;      // start divider on working[idx] / divisor
        logic div_take;       // commit quotient if remainder zero
        logic skip_value;     // value is 1: mark not all, next idx
        logic next_divisor;
        logic mul;
        logic out_start;      // idx=0 for output phase
        logic out_div_start;
        logic out_emit;
        logic summary;
    } cmd_t;

    typedef struct packed {
        logic idx_last;
        logic cur_gt1;
        logic div_done;
        logic hit;
        logic any_gt1;
        logic divisor_max;
    } status_t;
endpackage
`default_nettype wire

[hdl/lcmgcd_div.sv]
`default_nettype none
// Restoring divider, one quotient bit per cycle, 16-bit operands
module lcmgcd_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [15:0] dividend,
    input  wire logic [15:0] divisor,
    output logic             done,
    output logic [15:0]      quotient,
    output logic [15:0]      remainder
);
    logic [15:0] q_reg, q_next;
    logic [16:0] r_reg, r_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [16:0] trial;
    logic [15:0] dvs_reg, dvs_next;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        done_next = 1'b0;
        dvs_next = dvs_reg;
        trial = '0;
        if (start)
        begin
            q_next = dividend;
            r_next = '0;
            cnt_next = 5'd16;
            run_next = 1'b1;
            dvs_next = divisor;
        end
        else if (run_reg)
        begin
            trial = {r_reg[15:0], q_reg[15]};
            q_next = {q_reg[14:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                r_next = trial - {1'b0, dvs_reg};
                q_next[0] = 1'b1;
            end
            else
            begin
                r_next = trial;
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                run_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quotient = q_reg;
    assign remainder = r_reg[15:0];
endmodule
`default_nettype wire

[hdl/lcmgcd_datapath.sv]
`default_nettype none
module lcmgcd_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire lcmgcd_pkg::in_item_t in_item,
    input  wire lcmgcd_pkg::cmd_t     cmd,
    output lcmgcd_pkg::status_t       status,
    output logic                      result_valid,
    output lcmgcd_pkg::out_item_t     result
);
    logic [15:0] orig_mem [lcmgcd_pkg::MaxValues];
    logic [15:0] work_mem [lcmgcd_pkg::MaxValues];
    logic [lcmgcd_pkg::CntW-1:0]  count_reg;
    logic [lcmgcd_pkg::IdxW-1:0]  idx_reg;
    logic [16:0] divisor_reg;
    logic [31:0] lcm_reg;
    logic [15:0] gcd_reg;
    logic [lcmgcd_pkg::StepW-1:0] steps_reg;
    logic        ovf_reg, hit_reg, all_reg, any_reg;
    logic        rv_reg;
    lcmgcd_pkg::out_item_t res_reg;
    logic [15:0] v_in, cur, dvd, dvs, quo, rem;
    logic        ddone;
    logic [47:0] prod;
    logic [15:0] gcd_eff;

    assign v_in = (in_item.value == 16'd0) ? 16'd1 : in_item.value;
    assign cur = work_mem[idx_reg];
    assign gcd_eff = (gcd_reg == 16'd0) ? 16'd1 : gcd_reg;
    assign dvd = cmd.out_div_start ? orig_mem[idx_reg] : cur;
    assign dvs = cmd.out_div_start ? gcd_eff : divisor_reg[15:0];
    assign prod = lcm_reg * divisor_reg[15:0];

    lcmgcd_div u_div (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start || cmd.out_div_start),
        .dividend(dvd), .divisor(dvs), .done(ddone),
        .quotient(quo), .remainder(rem)
    );

    assign status.idx_last = ({1'b0, idx_reg} == lcmgcd_pkg::CntW'(count_reg - 1'b1));
    assign status.cur_gt1 = cur > 16'd1;
    assign status.div_done = ddone;
    assign status.hit = hit_reg;
    assign status.any_gt1 = any_reg;
    assign status.divisor_max = divisor_reg[16];

    always_ff @(posedge clk)
    begin
        if (cmd.load && count_reg < lcmgcd_pkg::CntW'(lcmgcd_pkg::MaxValues))
        begin
            orig_mem[count_reg[lcmgcd_pkg::IdxW-1:0]] <= v_in;
            work_mem[count_reg[lcmgcd_pkg::IdxW-1:0]] <= v_in;
        end
        if (cmd.div_take && rem == 16'd0)
            work_mem[idx_reg] <= quo;
        res_reg <= '0;
        if (cmd.out_emit)
        begin
            res_reg.kind <= lcmgcd_pkg::KIND_SIMPLE;
            res_reg.item_value <= quo;
        end
        else if (cmd.mul && steps_reg < lcmgcd_pkg::StepW'(lcmgcd_pkg::MaxSteps))
        begin
            res_reg.kind <= lcmgcd_pkg::KIND_STEP;
            res_reg.item_value <= divisor_reg[15:0];
        end
        else if (cmd.summary)
        begin
            res_reg.kind <= lcmgcd_pkg::KIND_SUMMARY;
            res_reg.lcm_value <= lcm_reg;
            res_reg.gcd_value <= gcd_reg;
            res_reg.overflow <= ovf_reg;
            res_reg.last_result <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg <= '0;
            divisor_reg <= 17'd2;
            lcm_reg <= 32'd1;
            gcd_reg <= 16'd1;
            steps_reg <= '0;
            ovf_reg <= 1'b0;
            hit_reg <= 1'b0;
            all_reg <= 1'b1;
            any_reg <= 1'b0;
            rv_reg <= 1'b0;
        end
        else
        begin
            rv_reg <= cmd.out_emit || cmd.summary ||
                (cmd.mul && steps_reg < lcmgcd_pkg::StepW'(lcmgcd_pkg::MaxSteps));
            if (cmd.load && count_reg < lcmgcd_pkg::CntW'(lcmgcd_pkg::MaxValues))
                count_reg <= count_reg + 1'b1;
            if (cmd.scan_start || cmd.out_start)
            begin
                idx_reg <= '0;
                hit_reg <= 1'b0;
                all_reg <= 1'b1;
                any_reg <= 1'b0;
            end
            if (cmd.skip_value)
            begin
                all_reg <= 1'b0;
                if (!status.idx_last)
                    idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.div_take)
            begin
                if (rem == 16'd0)
                begin
                    hit_reg <= 1'b1;
                    if (quo > 16'd1)
                        any_reg <= 1'b1;
                end
                else
                begin
                    all_reg <= 1'b0;
                    any_reg <= 1'b1;
                end
                if (!status.idx_last)
                    idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.out_emit && !status.idx_last)
                idx_reg <= idx_reg + 1'b1;
            if (cmd.next_divisor)
                divisor_reg <= divisor_reg + 17'd1;
            if (cmd.mul)
            begin
                if (prod[47:32] != 16'd0)
                begin
                    lcm_reg <= 32'hFFFF_FFFF;
                    ovf_reg <= 1'b1;
                end
                else
                    lcm_reg <= prod[31:0];
                if (all_reg)
                    gcd_reg <= 16'(gcd_reg * divisor_reg[15:0]);
                if (steps_reg < lcmgcd_pkg::StepW'(lcmgcd_pkg::MaxSteps))
                    steps_reg <= steps_reg + 1'b1;
                else
                    ovf_reg <= 1'b1;
            end
            if (cmd.summary)
            begin
                count_reg <= '0;
                divisor_reg <= 17'd2;
                lcm_reg <= 32'd1;
                gcd_reg <= 16'd1;
                steps_reg <= '0;
                ovf_reg <= 1'b0;
            end
        end
    end

    assign result_valid = rv_reg;
    assign result = res_reg;
endmodule
`default_nettype wire

[hdl/lcmgcd_ctrl.sv]
`default_nettype none
module lcmgcd_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 last_value,
    input  wire lcmgcd_pkg::status_t  status,
    output lcmgcd_pkg::cmd_t          cmd,
    output logic                      busy
);
    lcmgcd_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lcmgcd_pkg::ST_LOAD:
                if (start && last_value)
                    state_next = lcmgcd_pkg::ST_SCAN;
            lcmgcd_pkg::ST_SCAN:
                if (status.cur_gt1)
                    state_next = lcmgcd_pkg::ST_DIV_WAIT;
                else if (status.idx_last)
                    state_next = lcmgcd_pkg::ST_STEP_END;
            lcmgcd_pkg::ST_DIV_WAIT:
                if (status.div_done)
                    state_next = status.idx_last ? lcmgcd_pkg::ST_STEP_END
                                                 : lcmgcd_pkg::ST_SCAN;
            lcmgcd_pkg::ST_STEP_END:
                if (status.hit)
                    state_next = lcmgcd_pkg::ST_MUL;
                else if (!status.any_gt1 || status.divisor_max)
                    state_next = lcmgcd_pkg::ST_OUT_DIV;
                else
                    state_next = lcmgcd_pkg::ST_SCAN;
            lcmgcd_pkg::ST_MUL:
                state_next = status.any_gt1 ? lcmgcd_pkg::ST_SCAN
                                            : lcmgcd_pkg::ST_OUT_DIV;
            lcmgcd_pkg::ST_OUT_DIV:
                state_next = lcmgcd_pkg::ST_OUT_WAIT;
            lcmgcd_pkg::ST_OUT_WAIT:
                if (status.div_done)
                    state_next = lcmgcd_pkg::ST_OUT_EMIT;
            lcmgcd_pkg::ST_OUT_EMIT:
                state_next = status.idx_last ? lcmgcd_pkg::ST_SUMMARY
                                             : lcmgcd_pkg::ST_OUT_DIV;
            lcmgcd_pkg::ST_SUMMARY:
                state_next = lcmgcd_pkg::ST_LOAD;
            default:
                state_next = lcmgcd_pkg::ST_LOAD;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        busy = 1'b1;
        unique case (state_reg)
            lcmgcd_pkg::ST_LOAD:
            begin
                busy = 1'b0;
                cmd.load = start;
                cmd.scan_start = start && last_value;
            end
            lcmgcd_pkg::ST_SCAN:
            begin
                cmd.div_start = status.cur_gt1;
                cmd.skip_value = !status.cur_gt1;
            end
            lcmgcd_pkg::ST_DIV_WAIT:
                cmd.div_take = status.div_done;
            lcmgcd_pkg::ST_STEP_END:
            begin
                cmd.next_divisor = !status.hit;
                cmd.scan_start = !status.hit && status.any_gt1 && !status.divisor_max;
                cmd.out_start = !status.hit && (!status.any_gt1 || status.divisor_max);
            end
            lcmgcd_pkg::ST_MUL:
            begin
                cmd.mul = 1'b1;
                cmd.scan_start = status.any_gt1;
                cmd.out_start = !status.any_gt1;
            end
            lcmgcd_pkg::ST_OUT_DIV:
                cmd.out_div_start = 1'b1;
            lcmgcd_pkg::ST_OUT_WAIT:
                ;
            lcmgcd_pkg::ST_OUT_EMIT:
                cmd.out_emit = 1'b1;
            lcmgcd_pkg::ST_SUMMARY:
                cmd.summary = 1'b1;
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lcmgcd_pkg::ST_LOAD;
        else
            state_reg <= state_next;
    end
endmodule
`default_nettype wire

[hdl/lcm_gcd_by_trial_factoring_top.sv]
`default_nettype none
// Numbers load at one transaction per cycle while busy is low; the last
// marked transaction starts factoring and raises busy. Each trial pass runs a
// serial divider once per value still above one; trial divisors step by one up
// to the largest remaining prime. Results appear as one-cycle done pulses and
// must be captured; the receiver cannot stall.
module lcm_gcd_by_trial_factoring_top (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire lcmgcd_pkg::in_item_t  in_item,
    output logic                       busy,
    output logic                       done,
    output lcmgcd_pkg::out_item_t      result
);
    `include "assert_macros.svh"

    lcmgcd_pkg::cmd_t    cmd;
    lcmgcd_pkg::status_t status;

    lcmgcd_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .last_value(in_item.last_value),
        .status(status), .cmd(cmd), .busy(busy)
    );

    lcmgcd_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .in_item(in_item), .cmd(cmd),
        .status(status), .result_valid(done), .result(result)
    );

    // the summary pulse lands in the first load cycle of the next set
    `ASSERT_IMPL(a_summary_ends, clk, rst_n, (done && result.last_result) |-> !busy)
    `ASSERT_IMPL(a_load_idle, clk, rst_n, cmd.load |-> !busy)
    `ASSERT_NEXT(a_mul_no_load, clk, rst_n, cmd.mul, busy)
endmodule
`default_nettype wire

[dv/tb_lcm_gcd_by_trial_factoring_top.sv]
`default_nettype none
module tb_lcm_gcd_by_trial_factoring_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int StallLimit = 400000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    lcmgcd_pkg::in_item_t  in_item = '0;
    logic                  busy;
    logic                  done;
    lcmgcd_pkg::out_item_t result;

    lcm_gcd_by_trial_factoring_top uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .in_item(in_item),
        .busy(busy),
        .done(done),
        .result(result)
    );

    always #4 clk = ~clk;

    lcmgcd_pkg::out_item_t expected_results[$];
    logic [15:0] held_values[lcmgcd_pkg::MaxValues];
    int          held_count = 0;
    int          idle_pct = 0;
    int          mismatches = 0;
    int          results_seen = 0;
    int          sets_done = 0;
    int          items_sent = 0;
    int          stall_cycles = 0;

    // factor the held set and queue every result it produces
    function automatic void factor_held_set();
        logic [15:0] work[lcmgcd_pkg::MaxValues];
        int unsigned divisor;
        longint unsigned lcm_acc;
        logic [15:0] gcd_acc;
        int          steps;
        logic        ovf;
        logic        hit;
        logic        all_hit;
        logic        live;
        logic [15:0] g;
        lcmgcd_pkg::out_item_t r;
        for (int i = 0; i < held_count; i++)
            work[i] = held_values[i];
        divisor = 2;
        lcm_acc = 1;
        gcd_acc = 16'd1;
        steps = 0;
        ovf = 1'b0;
        forever
        begin
            live = 1'b0;
            for (int i = 0; i < held_count; i++)
                if (work[i] > 1)
                    live = 1'b1;
            if (!live || divisor > 65535)
                break;
            hit = 1'b0;
            all_hit = 1'b1;
            for (int i = 0; i < held_count; i++)
            begin
                if (work[i] > 1 && work[i] % divisor == 0)
                begin
                    work[i] = work[i] / divisor;
                    hit = 1'b1;
                end
                else
                    all_hit = 1'b0;
            end
            if (!hit)
            begin
                divisor++;
                continue;
            end
            lcm_acc = lcm_acc * divisor;
            if (lcm_acc > 64'hFFFF_FFFF)
            begin
                lcm_acc = 64'hFFFF_FFFF;
                ovf = 1'b1;
            end
            if (all_hit)
                gcd_acc = 16'(gcd_acc * divisor);
            if (steps < lcmgcd_pkg::MaxSteps)
            begin
                r = '0;
                r.kind = lcmgcd_pkg::KIND_STEP;
                r.item_value = 16'(divisor);
                expected_results.push_back(r);
                steps++;
            end
            else
                ovf = 1'b1;
        end
        g = (gcd_acc != 0) ? gcd_acc : 16'd1;
        for (int i = 0; i < held_count; i++)
        begin
            r = '0;
            r.kind = lcmgcd_pkg::KIND_SIMPLE;
            r.item_value = held_values[i] / g;
            expected_results.push_back(r);
        end
        r = '0;
        r.kind = lcmgcd_pkg::KIND_SUMMARY;
        r.lcm_value = 32'(lcm_acc);
        r.gcd_value = gcd_acc;
        r.overflow = ovf;
        r.last_result = 1'b1;
        expected_results.push_back(r);
        held_count = 0;
        sets_done++;
    endfunction

    task automatic send_value(input logic [15:0] v, input logic mark);
        int gap;
        @(negedge clk);
        start = 1'b1;
        in_item.value = v;
        in_item.last_value = mark;
        do @(posedge clk); while (busy);
        items_sent++;
        if (held_count < lcmgcd_pkg::MaxValues)
        begin
            held_values[held_count] = (v == 0) ? 16'd1 : v;
            held_count++;
        end
        if (mark)
            factor_held_set();
        if ($urandom_range(99) < idle_pct)
        begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic release_start();
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic wait_drained();
        release_start();
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_set(input logic [15:0] vals[$]);
        for (int i = 0; i < vals.size(); i++)
            send_value(vals[i], i == vals.size() - 1);
    endtask

    // mostly small-prime products so factoring stays short
    function automatic logic [15:0] pick_value(input int unsigned base);
        int unsigned v;
        int unsigned p;
        int unsigned primes[8] = '{2, 3, 5, 7, 11, 13, 17, 31};
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 5)
            return 16'd0;
        if (sel < 15)
            return 16'($urandom_range(1, 255));
        v = base;
        repeat ($urandom_range(1, 14))
        begin
            p = primes[$urandom_range(7)];
            if (v * p <= 65535)
                v = v * p;
        end
        return 16'(v);
    endfunction

    task automatic test_extremes();
        send_set('{16'hFFFF, 16'h0000, 16'h0001});
        send_set('{16'h0001});
        send_set('{16'hFFFF});
        send_set('{16'hFFFE, 16'h8000});
    endtask

    task automatic test_common_divisor();
        send_set('{16'd360, 16'd840, 16'd1260});
        send_set('{16'd4099});
    endtask

    task automatic test_set_full();
        send_set('{16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7, 16'd8, 16'd9, 16'd10});
    endtask

    task automatic test_step_limit_overflow();
        // 36 steps and an LCM far past 32 bits
        send_set('{16'd32768, 16'd59049, 16'd15625, 16'd16807});
        wait_drained();
    endtask

    task automatic test_random_sets(input int n_items);
        int unsigned base;
        int          len;
        int          target;
        logic [15:0] vals[$];
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            vals.delete();
            len = ($urandom_range(9) == 0) ? $urandom_range(8, 10) : $urandom_range(1, 5);
            base = ($urandom_range(2) == 0) ? $urandom_range(1, 12) : 1;
            repeat (len)
                vals.push_back(pick_value(base));
            send_set(vals);
        end
    endtask

    always @(posedge clk)
    begin
        lcmgcd_pkg::out_item_t want;
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (done)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %p", result);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.kind !== want.kind || result.item_value !== want.item_value
                        || result.lcm_value !== want.lcm_value
                        || result.gcd_value !== want.gcd_value
                        || result.overflow !== want.overflow
                        || result.last_result !== want.last_result)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p got %p", want, result);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_cycles >= StallLimit)
        begin
            $display("timeout waiting for a transaction");
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_extremes();
        test_common_divisor();
        test_set_full();
        test_step_limit_overflow();
        idle_pct = 6;
        test_random_sets(120);
        idle_pct = 58;
        test_random_sets(115);
        idle_pct = 0;
        test_random_sets(115);
        wait_drained();
        repeat (100) @(posedge clk);
        $display("sent %0d numbers in %0d sets, checked %0d results", items_sent,
                 sets_done, results_seen);
        $display("covered zero/extreme values, full sets, step cut and LCM saturation");
        if (mismatches == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     expected_results.size());
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
+incdir+hdl
hdl/lcmgcd_pkg.sv
hdl/lcmgcd_div.sv
hdl/lcmgcd_datapath.sv
hdl/lcmgcd_ctrl.sv
hdl/lcm_gcd_by_trial_factoring_top.sv
dv/tb_lcm_gcd_by_trial_factoring_top.sv
